### rtl/chbd_pkg.sv
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; used by every rtl file by scoped name.
package chbd_pkg;

  localparam int unsigned MaxSizeDigits = 8;
  localparam int unsigned DigitCntW     = 4;
  localparam int unsigned CountW        = 32;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned ModeW         = 2;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [ByteW-1:0] CharLf = 8'h0A;
  localparam logic [ByteW-1:0] CharCr = 8'h0D;

  localparam logic [CountW-1:0] TrailerLen = 32'd2;

  typedef enum logic [ModeW-1:0] {
    MODE_KNOWN   = 2'd0,
    MODE_UNKNOWN = 2'd1,
    MODE_CHUNKED = 2'd2,
    MODE_DONE    = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BODY_MODE   = 1'd0,
    REG_BODY_LENGTH = 1'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_SIZE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_TRAIL = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_valid;
    logic             body_done;
    logic             format_error;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

### rtl/chbd_ctrl.sv
// Decoder state registers and the per-beat next-state and result logic.
// Depends on chbd_pkg.
module chbd_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chbd_pkg::mode_e              body_mode_i,
  input  logic [chbd_pkg::CountW-1:0]  body_length_i,
  input  logic                         beat_i,
  input  logic [chbd_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         segment_end_i,
  output chbd_pkg::res_t               res_o
);

  chbd_pkg::phase_e                   phase_q, phase_d;
  logic [chbd_pkg::DigitCntW-1:0]     digit_cnt_q, digit_cnt_d;
  logic [chbd_pkg::CountW-1:0]        size_q, size_d;
  logic [chbd_pkg::CountW-1:0]        remaining_q, remaining_d;
  logic [chbd_pkg::CountW-1:0]        sent_q, sent_d;
  logic                               finished_q, finished_d;
  logic                               error_q, error_d;
  logic [chbd_pkg::CountW-1:0]        rem_dec;
  chbd_pkg::hex_t                     hex;

  always_comb begin
    phase_d     = phase_q;
    digit_cnt_d = digit_cnt_q;
    size_d      = size_q;
    remaining_d = remaining_q;
    sent_d      = sent_q;
    finished_d  = finished_q;
    error_d     = error_q;
    rem_dec     = remaining_q - 32'd1;
    hex         = chbd_pkg::hex_decode(data_byte_i);
    res_o       = '0;

    if (!finished_q && !error_q && body_mode_i != chbd_pkg::MODE_DONE) begin
      sent_d = sent_q + 32'd1;
      if (body_mode_i == chbd_pkg::MODE_KNOWN || body_mode_i == chbd_pkg::MODE_UNKNOWN) begin
        res_o.out_byte  = data_byte_i;
        res_o.out_valid = 1'b1;
        if (body_mode_i == chbd_pkg::MODE_KNOWN && segment_end_i &&
            sent_d == body_length_i) begin
          finished_d      = 1'b1;
          res_o.body_done = 1'b1;
        end
      end else begin
        case (phase_q)
          chbd_pkg::PH_DATA: begin
            res_o.out_byte  = data_byte_i;
            res_o.out_valid = 1'b1;
            remaining_d     = rem_dec;
            if (rem_dec == '0) begin
              phase_d     = chbd_pkg::PH_TRAIL;
              remaining_d = chbd_pkg::TrailerLen;
            end
          end
          chbd_pkg::PH_TRAIL: begin
            remaining_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d     = chbd_pkg::PH_SIZE;
              digit_cnt_d = '0;
              size_d      = '0;
            end
          end
          default: begin
            if (data_byte_i == chbd_pkg::CharLf) begin
              if (digit_cnt_q == '0) begin
                error_d = 1'b1;
              end else if (size_q == '0) begin
                finished_d      = 1'b1;
                res_o.body_done = 1'b1;
                phase_d         = chbd_pkg::PH_DATA;
              end else begin
                phase_d     = chbd_pkg::PH_DATA;
                remaining_d = size_q;
              end
            end else if (data_byte_i != chbd_pkg::CharCr) begin
              if (!hex.valid ||
                  digit_cnt_q >= chbd_pkg::DigitCntW'(chbd_pkg::MaxSizeDigits) ||
                  size_q[chbd_pkg::CountW-1 -: 4] != 4'd0) begin
                error_d = 1'b1;
              end else begin
                size_d      = {size_q[chbd_pkg::CountW-5:0], hex.value};
                digit_cnt_d = digit_cnt_q + 4'd1;
              end
            end
          end
        endcase
      end
    end
    res_o.format_error = error_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= chbd_pkg::PH_SIZE;
      digit_cnt_q <= '0;
      size_q      <= '0;
      remaining_q <= '0;
      sent_q      <= '0;
      finished_q  <= 1'b0;
      error_q     <= 1'b0;
    end else if (beat_i) begin
      phase_q     <= phase_d;
      digit_cnt_q <= digit_cnt_d;
      size_q      <= size_d;
      remaining_q <= remaining_d;
      sent_q      <= sent_d;
      finished_q  <= finished_d;
      error_q     <= error_d;
    end
  end

endmodule

### rtl/chbd_out_buf.sv
// Two-entry result buffer that parts the input and output handshakes.
// Depends on chbd_pkg.
module chbd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  chbd_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           stall_i,
  output chbd_pkg::res_t data_o
);

  chbd_pkg::res_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

### rtl/http_chunked_body_decoder.sv
// HTTP/1.1 response body decoder: known length, unknown length and chunked.
// Each result beat is registered in the two-entry result buffer before it is presented.
// Throughput: one beat per cycle; the two-entry result buffer stalls input when full.
// Reset: asynchronous, active low; clears config, decoder state and buffer.
// Instantiates chbd_ctrl and chbd_out_buf; depends on chbd_pkg.
module http_chunked_body_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [chbd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [chbd_pkg::CountW-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [chbd_pkg::ByteW-1:0]         data_byte_i,
  input  logic                               segment_end_i,
  output logic                               res_valid_o,
  input  logic                               res_stall_i,
  output logic [chbd_pkg::ByteW-1:0]         out_byte_o,
  output logic                               out_valid_o,
  output logic                               body_done_o,
  output logic                               format_error_o
);

  chbd_pkg::mode_e              body_mode_q;
  logic [chbd_pkg::CountW-1:0]  body_length_q;
  logic                         beat;
  logic                         full;
  chbd_pkg::res_t               res;
  chbd_pkg::res_t               res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_mode_q   <= chbd_pkg::MODE_KNOWN;
      body_length_q <= '0;
    end else if (cfg_we_i) begin
      case (chbd_pkg::reg_idx_e'(cfg_idx_i))
        chbd_pkg::REG_BODY_MODE:   body_mode_q   <= chbd_pkg::mode_e'(cfg_data_i[1:0]);
        chbd_pkg::REG_BODY_LENGTH: body_length_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full;
  assign beat       = in_valid_i && !full;

  chbd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .body_mode_i   (body_mode_q),
    .body_length_i (body_length_q),
    .beat_i        (beat),
    .data_byte_i   (data_byte_i),
    .segment_end_i (segment_end_i),
    .res_o         (res)
  );

  chbd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (beat),
    .push_data_i (res),
    .full_o      (full),
    .valid_o     (res_valid_o),
    .stall_i     (res_stall_i),
    .data_o      (res_out)
  );

  assign out_byte_o     = res_out.out_byte;
  assign out_valid_o    = res_out.out_valid;
  assign body_done_o    = res_out.body_done;
  assign format_error_o = res_out.format_error;

endmodule

### tb/tb_http_chunked_body_decoder.sv
// Self-checking bench for http_chunked_body_decoder: known, unknown and chunked bodies.
// Predicts every result beat in a local decoder copy and compares field by field.
// Depends on chbd_pkg and the http_chunked_body_decoder RTL.
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [7:0] BadChars [5] = '{8'h20, 8'h2D, 8'h78, 8'h3B, 8'h09};

  typedef enum int {
    END_BY_LENGTH,
    END_BY_LAST_CHUNK,
    ERR_BAD_DIGIT,
    ERR_LONG_SIZE,
    ERR_EMPTY_SIZE
  } body_end_e;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [chbd_pkg::CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [chbd_pkg::CountW-1:0]    cfg_data_i    = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [chbd_pkg::ByteW-1:0]     data_byte_i   = '0;
  logic                           segment_end_i = 1'b0;
  logic                           res_valid_o;
  logic                           res_stall_i   = 1'b0;
  logic [chbd_pkg::ByteW-1:0]     out_byte_o;
  logic                           out_valid_o;
  logic                           body_done_o;
  logic                           format_error_o;

  // decoder copy
  chbd_pkg::mode_e                body_mode_q = chbd_pkg::MODE_KNOWN;
  logic [chbd_pkg::CountW-1:0]    body_len_q  = '0;
  chbd_pkg::phase_e               chunk_phase = chbd_pkg::PH_SIZE;
  logic [chbd_pkg::DigitCntW-1:0] digit_cnt   = '0;
  logic [chbd_pkg::CountW-1:0]    size_acc    = '0;
  logic [chbd_pkg::CountW-1:0]    chunk_left  = '0;
  logic [chbd_pkg::CountW-1:0]    sent_cnt    = '0;
  logic                           body_ended  = 1'b0;
  logic                           size_error  = 1'b0;
  chbd_pkg::res_t                 decoded_q[$];

  int unsigned in_gap_max   = 0;
  int unsigned out_wait_max = 0;
  int unsigned out_wait     = 0;
  int unsigned hold_cycles  = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;

  http_chunked_body_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .segment_end_i  (segment_end_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .body_done_o    (body_done_o),
    .format_error_o (format_error_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return 8'h30 + v;
    return (lower ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic seg);
    chbd_pkg::res_t r;
    int             digit;
    r = '0;
    if (!body_ended && !size_error && body_mode_q != chbd_pkg::MODE_DONE) begin
      sent_cnt = sent_cnt + 1;
      if (body_mode_q == chbd_pkg::MODE_KNOWN || body_mode_q == chbd_pkg::MODE_UNKNOWN) begin
        r.out_byte  = b;
        r.out_valid = 1'b1;
        if (body_mode_q == chbd_pkg::MODE_KNOWN && seg && sent_cnt == body_len_q) begin
          body_ended  = 1'b1;
          r.body_done = 1'b1;
        end
      end else if (chunk_phase == chbd_pkg::PH_DATA) begin
        r.out_byte  = b;
        r.out_valid = 1'b1;
        chunk_left  = chunk_left - 1;
        if (chunk_left == 0) begin
          chunk_phase = chbd_pkg::PH_TRAIL;
          chunk_left  = chbd_pkg::TrailerLen;
        end
      end else if (chunk_phase == chbd_pkg::PH_TRAIL) begin
        chunk_left = chunk_left - 1;
        if (chunk_left == 0) begin
          chunk_phase = chbd_pkg::PH_SIZE;
          digit_cnt   = '0;
          size_acc    = '0;
        end
      end else if (b == chbd_pkg::CharLf) begin
        if (digit_cnt == 0) begin
          size_error = 1'b1;
        end else if (size_acc == 0) begin
          body_ended  = 1'b1;
          r.body_done = 1'b1;
          chunk_phase = chbd_pkg::PH_DATA;
        end else begin
          chunk_phase = chbd_pkg::PH_DATA;
          chunk_left  = size_acc;
        end
      end else if (b != chbd_pkg::CharCr) begin
        digit = nibble_of(b);
        if (digit < 0 || digit_cnt >= chbd_pkg::MaxSizeDigits ||
            size_acc > 32'h0FFF_FFFF) begin
          size_error = 1'b1;
        end else begin
          size_acc  = {size_acc[27:0], 4'(digit)};
          digit_cnt = digit_cnt + 1'b1;
        end
      end
    end
    r.format_error = size_error;
    decoded_q.push_back(r);
  endtask

  // Valid stays high across back-to-back beats; it drops for a gap or in wait_idle.
  task automatic send_beat(input logic [7:0] b, input logic seg);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    segment_end_i <= seg;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, seg);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input chbd_pkg::reg_idx_e idx,
                           input logic [chbd_pkg::CountW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == chbd_pkg::REG_BODY_MODE) body_mode_q = chbd_pkg::mode_e'(val[1:0]);
    else body_len_q = val;
    @(posedge clk_i);
  endtask

  task automatic send_chunk(input int unsigned len);
    int unsigned sig;
    int unsigned total;
    sig = 1;
    while (sig < 8 && (len >> (4 * sig)) != 0) sig++;
    total = ($urandom_range(0, 3) == 0) ? $urandom_range(sig, chbd_pkg::MaxSizeDigits) : sig;
    for (int i = int'(total) - 1; i >= 0; i--) begin
      if ($urandom_range(0, 7) == 0) send_beat(chbd_pkg::CharCr, coin());
      send_beat(hex_char(4'(len >> (4 * i)), coin()), coin());
    end
    if ($urandom_range(0, 3) != 0) send_beat(chbd_pkg::CharCr, coin());
    send_beat(chbd_pkg::CharLf, coin());
    repeat (len) send_beat(rand_byte(), coin());
    if ($urandom_range(0, 3) == 0) begin
      repeat (2) send_beat(rand_byte(), coin());
    end else begin
      send_beat(chbd_pkg::CharCr, coin());
      send_beat(chbd_pkg::CharLf, coin());
    end
  endtask

  task automatic test_known_length();
    in_gap_max   = 0;
    out_wait_max = 0;
    write_reg(chbd_pkg::REG_BODY_LENGTH, 32'hFFFF_FFFF);
    write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_KNOWN);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(chbd_pkg::CharLf, 1'b1);
    send_beat(chbd_pkg::CharCr, 1'b0);
    // count reaches the length without a segment end: body goes on
    wait_idle();
    write_reg(chbd_pkg::REG_BODY_LENGTH, sent_cnt + 2);
    send_beat(8'h5A, 1'b1);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h3C, 1'b1);
    in_gap_max   = 10;
    out_wait_max = 10;
    repeat (80) send_beat(rand_byte(), coin());
  endtask

  task automatic test_unknown_length();
    wait_idle();
    write_reg(chbd_pkg::REG_BODY_LENGTH, 32'h0000_0000);
    write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_UNKNOWN);
    in_gap_max = 0;
    repeat (40) send_beat(rand_byte(), coin());
    in_gap_max   = 10;
    out_wait_max = 0;
    repeat (40) send_beat(rand_byte(), coin());
    out_wait_max = 10;
  endtask

  task automatic test_output_backpressure();
    in_gap_max  = 0;
    hold_cycles = 300;
    repeat (40) send_beat(rand_byte(), coin());
    in_gap_max = 10;
  endtask

  task automatic test_finished_by_headers();
    wait_idle();
    write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_DONE);
    repeat (30) send_beat(rand_byte(), coin());
  endtask

  task automatic test_chunked_body();
    wait_idle();
    write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_CHUNKED);
    send_beat(8'h30, 1'b0);
    send_beat(8'h61, 1'b1);
    send_beat(chbd_pkg::CharCr, 1'b0);
    send_beat(chbd_pkg::CharLf, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    repeat (8) send_beat(rand_byte(), coin());
    send_beat(chbd_pkg::CharCr, 1'b0);
    send_beat(chbd_pkg::CharLf, 1'b1);
    for (int n = 0; n < 20; n++) begin
      in_gap_max   = (n % 5 == 4) ? 0 : 10;
      out_wait_max = (n % 5 == 3) ? 0 : 10;
      send_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                             : $urandom_range(1, 16));
    end
    in_gap_max   = 10;
    out_wait_max = 10;
  endtask

  task automatic test_mode_switch_mid_chunk();
    send_beat(8'h35, coin());
    send_beat(chbd_pkg::CharCr, coin());
    send_beat(chbd_pkg::CharLf, coin());
    repeat (2) send_beat(rand_byte(), coin());
    wait_idle();
    write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_UNKNOWN);
    repeat (4) send_beat(rand_byte(), coin());
    wait_idle();
    write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_DONE);
    repeat (3) send_beat(rand_byte(), coin());
    wait_idle();
    write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_CHUNKED);
    repeat (5) send_beat(rand_byte(), coin());
  endtask

  // Ending and errors are sticky, so each run takes one of them, then drops noise.
  task automatic test_body_end();
    body_end_e                   kind;
    logic [7:0]                  bad;
    int unsigned                 n;
    logic [chbd_pkg::CountW-1:0] val;
    kind = body_end_e'($urandom_range(0, 4));
    case (kind)
      END_BY_LENGTH: begin
        n = $urandom_range(1, 8);
        wait_idle();
        write_reg(chbd_pkg::REG_BODY_LENGTH, sent_cnt + n);
        write_reg(chbd_pkg::REG_BODY_MODE, chbd_pkg::MODE_KNOWN);
        repeat (n - 1) send_beat(rand_byte(), 1'b0);
        send_beat(rand_byte(), 1'b1);
      end
      END_BY_LAST_CHUNK: begin
        repeat ($urandom_range(1, 3)) send_beat(8'h30, coin());
        send_beat(chbd_pkg::CharCr, coin());
        send_beat(chbd_pkg::CharLf, coin());
      end
      ERR_BAD_DIGIT: begin
        repeat ($urandom_range(0, 3)) begin
          send_beat(hex_char(4'($urandom_range(0, 15)), coin()), coin());
        end
        if (coin()) begin
          bad = BadChars[$urandom_range(0, 4)];
        end else begin
          do bad = rand_byte();
          while (nibble_of(bad) >= 0 || bad == chbd_pkg::CharCr || bad == chbd_pkg::CharLf);
        end
        send_beat(bad, coin());
      end
      ERR_LONG_SIZE: begin
        repeat (chbd_pkg::MaxSizeDigits + 1) begin
          send_beat(hex_char(4'($urandom_range(0, 15)), coin()), coin());
        end
      end
      default: begin
        send_beat(chbd_pkg::CharCr, coin());
        send_beat(chbd_pkg::CharLf, coin());
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      val = $urandom();
      write_reg(chbd_pkg::REG_BODY_MODE, val);
      repeat (10) send_beat(rand_byte(), coin());
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    chbd_pkg::res_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual out_byte %h",
                 $time, out_byte_o);
        err_cnt++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.out_byte, out_byte_o);
        check_field("out_valid", 8'(want.out_valid), 8'(out_valid_o));
        check_field("body_done", 8'(want.body_done), 8'(body_done_o));
        check_field("format_error", 8'(want.format_error), 8'(format_error_o));
      end
    end
  end

  // Draw a wait after each taken beat; a long hold overrides it.
  always @(posedge clk_i) begin
    if (res_valid_o && !res_stall_i) out_wait = $urandom_range(0, out_wait_max);
    if (hold_cycles != 0) begin
      hold_cycles--;
      res_stall_i <= 1'b1;
    end else if (out_wait != 0) begin
      out_wait--;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= 1'b0;
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_known_length();
    test_unknown_length();
    test_output_backpressure();
    test_finished_by_headers();
    test_chunked_body();
    test_mode_switch_mid_chunk();
    test_body_end();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
